// ----- hw/rtl/lsfc_pkg.sv -----
// lsfc_pkg: widths, depths and state codes for the shared-factor chain block
// no dependencies
package lsfc_pkg;

    localparam int VALUE_BITS  = 17;
    localparam int LENGTH_BITS = 16;
    localparam int MAX_VALUE   = 131071;
    localparam int MAX_PICKS   = 8;
    localparam int PICK_BITS   = $clog2(MAX_PICKS);
    localparam int CNT_BITS    = PICK_BITS + 1;
    // trial divisors stay at or below sqrt(MAX_VALUE) + a wheel step
    localparam int DIV_BITS    = 9;
    localparam int SQ_BITS     = 2 * DIV_BITS;
    localparam int DIV_STEPS   = (VALUE_BITS + 1) / 2;
    localparam int STEP_BITS   = $clog2(DIV_STEPS + 1);
    localparam int MEM_DEPTH   = 1 << VALUE_BITS;

    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b0000000001,
        ST_IDLE   = 10'b0000000010,
        ST_CHECK  = 10'b0000000100,
        ST_DIV    = 10'b0000001000,
        ST_RDWAIT = 10'b0000010000,
        ST_LEFT   = 10'b0000100000,
        ST_LWAIT  = 10'b0001000000,
        ST_FINAL  = 10'b0010000000,
        ST_WRITE  = 10'b0100000000,
        ST_DONE   = 10'b1000000000
    } state_t;

endpackage

// ----- hw/rtl/longest_shared_factor_chain_top.sv -----
// longest_shared_factor_chain_top: prime factoring by trial division plus a
// per-prime chain table in a synchronous memory addressed by the prime value
// depends on lsfc_pkg
// trial division takes 2 quotient bits a cycle over a 6k+-1 wheel up to
// sqrt(value), dividing each prime power out in turn, with a table read per
// new prime and a write per prime found; one transaction at a time
// reset: async active low; a clearing pass over all 131072 table entries
// zeroes the table before the first input transaction is taken
module longest_shared_factor_chain_top
    import lsfc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [VALUE_BITS-1:0]  value,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [LENGTH_BITS-1:0] chain_here,
    output logic [LENGTH_BITS-1:0] best_length
);

    state_t                 state_reg, state_next;
    logic [VALUE_BITS-1:0]  clr_reg, clr_next;
    logic [VALUE_BITS-1:0]  v_reg, v_next;
    logic [VALUE_BITS-1:0]  rest_reg, rest_next;
    logic [DIV_BITS-1:0]    d_reg, d_next;
    logic                   wheel_reg, wheel_next;
    logic                   hit_reg, hit_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [CNT_BITS-1:0]    widx_reg, widx_next;
    logic [LENGTH_BITS-1:0] top_reg, top_next;
    logic [LENGTH_BITS-1:0] here_reg, here_next;
    logic [LENGTH_BITS-1:0] best_reg, best_next;
    logic [VALUE_BITS-1:0]  picks_reg [MAX_PICKS];
    logic [VALUE_BITS-1:0]  picks_next [MAX_PICKS];
    logic [VALUE_BITS:0]    dvd_reg, dvd_next;
    logic [VALUE_BITS:0]    quo_reg, quo_next;
    logic [DIV_BITS-1:0]    rem_reg, rem_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;
    logic                   outv_reg, outv_next;
    logic [LENGTH_BITS-1:0] oc_reg, oc_next;
    logic [LENGTH_BITS-1:0] ob_reg, ob_next;

    logic [LENGTH_BITS-1:0] chain_mem [MEM_DEPTH];
    logic                   mem_we, mem_re;
    logic [VALUE_BITS-1:0]  mem_waddr, mem_raddr;
    logic [LENGTH_BITS-1:0] mem_wdata, rdata_reg;

    logic [SQ_BITS-1:0]     sq;
    logic [DIV_BITS:0]      r_work;
    logic [DIV_BITS-1:0]    r_acc;
    logic [VALUE_BITS:0]    dv_acc, q_acc;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            chain_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= chain_mem[mem_raddr];
        end
    end

    assign sq = {{DIV_BITS{1'b0}}, d_reg} * {{DIV_BITS{1'b0}}, d_reg};

    // two restoring division steps per cycle
    always_comb
    begin
        r_acc  = rem_reg;
        dv_acc = dvd_reg;
        q_acc  = quo_reg;
        r_work = '0;
        for (int i = 0; i < 2; i++)
        begin
            r_work = {r_acc, dv_acc[VALUE_BITS]};
            dv_acc = {dv_acc[VALUE_BITS-1:0], 1'b0};
            if (r_work >= {1'b0, d_reg})
            begin
                r_work = r_work - {1'b0, d_reg};
                q_acc  = {q_acc[VALUE_BITS-1:0], 1'b1};
            end
            else
            begin
                q_acc  = {q_acc[VALUE_BITS-1:0], 1'b0};
            end
            r_acc = r_work[DIV_BITS-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        v_next     = v_reg;
        rest_next  = rest_reg;
        d_next     = d_reg;
        wheel_next = wheel_reg;
        hit_next   = hit_reg;
        cnt_next   = cnt_reg;
        widx_next  = widx_reg;
        top_next   = top_reg;
        here_next  = here_reg;
        best_next  = best_reg;
        picks_next = picks_reg;
        dvd_next   = dvd_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        outv_next  = outv_reg;
        oc_next    = oc_reg;
        ob_next    = ob_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = clr_reg;
        mem_raddr  = {{(VALUE_BITS-DIV_BITS){1'b0}}, d_reg};
        mem_wdata  = '0;
        in_stall   = (state_reg != ST_IDLE);

        if (outv_reg && !out_stall)
        begin
            outv_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == {VALUE_BITS{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    v_next     = value;
                    rest_next  = value;
                    d_next     = DIV_BITS'(2);
                    wheel_next = 1'b0;
                    hit_next   = 1'b0;
                    cnt_next   = '0;
                    top_next   = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sq > {1'b0, v_reg})
                begin
                    state_next = ST_LEFT;
                end
                else
                begin
                    dvd_next   = {1'b0, rest_reg};
                    quo_next   = '0;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                dvd_next  = dv_acc;
                quo_next  = q_acc;
                rem_next  = r_acc;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_BITS'(DIV_STEPS - 1))
                begin
                    if (r_acc == '0)
                    begin
                        rest_next = q_acc[VALUE_BITS-1:0];
                        if (!hit_reg)
                        begin
                            hit_next = 1'b1;
                            if (cnt_reg < CNT_BITS'(MAX_PICKS))
                            begin
                                picks_next[cnt_reg[PICK_BITS-1:0]] =
                                    {{(VALUE_BITS-DIV_BITS){1'b0}}, d_reg};
                                cnt_next   = cnt_reg + 1'b1;
                            end
                            mem_re     = 1'b1;
                            mem_raddr  = {{(VALUE_BITS-DIV_BITS){1'b0}}, d_reg};
                            state_next = ST_RDWAIT;
                        end
                        else
                        begin
                            state_next = ST_CHECK;
                        end
                    end
                    else
                    begin
                        hit_next = 1'b0;
                        if (d_reg == DIV_BITS'(2))
                        begin
                            d_next = DIV_BITS'(3);
                        end
                        else if (d_reg == DIV_BITS'(3))
                        begin
                            d_next     = DIV_BITS'(5);
                            wheel_next = 1'b0;
                        end
                        else
                        begin
                            d_next     = d_reg + (wheel_reg ? DIV_BITS'(4) : DIV_BITS'(2));
                            wheel_next = !wheel_reg;
                        end
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_RDWAIT:
            begin
                if (rdata_reg > top_reg)
                begin
                    top_next = rdata_reg;
                end
                state_next = ST_CHECK;
            end
            ST_LEFT:
            begin
                // leftover above the square root is itself prime
                if (rest_reg > VALUE_BITS'(1) && cnt_reg < CNT_BITS'(MAX_PICKS))
                begin
                    picks_next[cnt_reg[PICK_BITS-1:0]] = rest_reg;
                    cnt_next   = cnt_reg + 1'b1;
                    mem_re     = 1'b1;
                    mem_raddr  = rest_reg;
                    state_next = ST_LWAIT;
                end
                else
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_LWAIT:
            begin
                if (rdata_reg > top_reg)
                begin
                    top_next = rdata_reg;
                end
                state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                widx_next = '0;
                if (cnt_reg == '0)
                begin
                    here_next  = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    here_next  = (top_reg == {LENGTH_BITS{1'b1}}) ? top_reg
                                                                  : top_reg + 1'b1;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                mem_we    = 1'b1;
                mem_waddr = picks_reg[widx_reg[PICK_BITS-1:0]];
                mem_wdata = here_reg;
                widx_next = widx_reg + 1'b1;
                if (here_reg > best_reg)
                begin
                    best_next = here_reg;
                end
                if (widx_next == cnt_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!outv_reg || !out_stall)
                begin
                    outv_next  = 1'b1;
                    oc_next    = here_reg;
                    ob_next    = best_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            outv_reg  <= 1'b0;
            best_reg  <= LENGTH_BITS'(1);
            cnt_reg   <= '0;
            widx_reg  <= '0;
            hit_reg   <= 1'b0;
            wheel_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            outv_reg  <= outv_next;
            best_reg  <= best_next;
            cnt_reg   <= cnt_next;
            widx_reg  <= widx_next;
            hit_reg   <= hit_next;
            wheel_reg <= wheel_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg     <= v_next;
        rest_reg  <= rest_next;
        d_reg     <= d_next;
        top_reg   <= top_next;
        here_reg  <= here_next;
        picks_reg <= picks_next;
        dvd_reg   <= dvd_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        oc_reg    <= oc_next;
        ob_reg    <= ob_next;
    end

    assign out_valid   = outv_reg;
    assign chain_here  = oc_reg;
    assign best_length = ob_reg;

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("table write while idle");

    a_pick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(MAX_PICKS))
        else $error("factor list overflow");

    a_best_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (best_length != '0 && chain_here <= best_length))
        else $error("result exceeds running best");

endmodule
